/* design/alp_pkg.sv */
// Package for the AC level probe debouncer.
// Holds shared widths, codes and the probe control struct.
// No dependencies.
package alp_pkg;

    // Sizes
    localparam int NUM_PROBES = 3;
    localparam int DELAY_W    = 16;
    localparam int CFG_IDX_W  = 2;

    // Register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_DELAY_LOW  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DELAY_MID  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DELAY_HIGH = 2'd2;

    // Request kinds carried on tuser
    localparam logic KIND_SENSE = 1'b0;
    localparam logic KIND_DELAY = 1'b1;

    // Drive line patterns, bit 0 = A, bit 1 = B
    localparam logic [1:0] DRV_OFF = 2'b00;
    localparam logic [1:0] DRV_A   = 2'b01;
    localparam logic [1:0] DRV_B   = 2'b10;
    localparam logic [1:0] DRV_AB  = 2'b11;

    // Sequencer phases
    typedef enum logic [1:0] {
        PH_DRIVE_A = 2'd0,
        PH_SAMPLE  = 2'd1,
        PH_DRIVE_B = 2'd2,
        PH_REST    = 2'd3
    } phase_t;

    // Per-probe control for one processed request
    typedef struct packed {
        logic sample_en;  // sense tick in the sampling phase
        logic count_en;   // delay tick
        logic sample;     // inverted pin level, 1 = wet
    } probe_ctl_t;

endpackage

/* design/alp_probe.sv */
// One probe qualifier: previous sample, settle counter, accepted level.
// Depends on alp_pkg.
module alp_probe (
    input  logic                        clk,
    input  logic                        rst_n,
    input  alp_pkg::probe_ctl_t         ctl,
    input  logic [alp_pkg::DELAY_W-1:0] delay,
    output logic                        level_next
);
    import alp_pkg::*;

    logic               prev_reg;
    logic               prev_next;
    logic               level_reg;
    logic [DELAY_W-1:0] cnt_reg;
    logic [DELAY_W-1:0] cnt_next;

    // Sample compare and countdown
    always_comb
    begin
        prev_next  = prev_reg;
        level_next = level_reg;
        cnt_next   = cnt_reg;
        if (ctl.count_en)
        begin
            if (cnt_reg != '0)
            begin
                cnt_next = cnt_reg - DELAY_W'(1);
            end
        end
        else if (ctl.sample_en)
        begin
            if (prev_reg == ctl.sample)
            begin
                if (cnt_reg == '0)
                begin
                    level_next = ctl.sample;
                end
            end
            else
            begin
                cnt_next = delay;
            end
            prev_next = ctl.sample;
        end
    end

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_reg  <= 1'b0;
            level_reg <= 1'b0;
            cnt_reg   <= '0;
        end
        else
        begin
            prev_reg  <= prev_next;
            level_reg <= level_next;
            cnt_reg   <= cnt_next;
        end
    end

endmodule

/* design/alp_seq.sv */
// Four-phase drive sequencer for the electrode pair.
// Depends on alp_pkg.
module alp_seq (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            step_en,
    output alp_pkg::phase_t phase,
    output logic [1:0]      drive_next
);
    import alp_pkg::*;

    phase_t     phase_reg;
    phase_t     phase_next;
    logic [1:0] drive_reg;

    // Next phase and drive pattern
    always_comb
    begin
        phase_next = phase_reg;
        drive_next = drive_reg;
        if (step_en)
        begin
            unique case (phase_reg)
                PH_DRIVE_A:
                begin
                    drive_next = DRV_A;
                    phase_next = PH_SAMPLE;
                end
                PH_SAMPLE:  phase_next = PH_DRIVE_B;
                PH_DRIVE_B:
                begin
                    drive_next = DRV_B;
                    phase_next = PH_REST;
                end
                PH_REST:    phase_next = PH_DRIVE_A;
                default:    phase_next = PH_DRIVE_A;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_DRIVE_A;
            drive_reg <= DRV_OFF;
        end
        else
        begin
            phase_reg <= phase_next;
            drive_reg <= drive_next;
        end
    end

    assign phase = phase_reg;

endmodule

/* design/ac_level_probe_debouncer.sv */
// Path: a request moves from the input register to the result register when that one is free or draining.
// Throughput: one request per cycle while m_axis_tready stays high; the input
// register and the result register each take a new request while the one ahead moves on.
// Reset (rst_n, async, active low) clears phase, drives, probe state,
// delay registers and both valid flags. No clearing pass.
module ac_level_probe_debouncer (
    input  logic                          clk,
    input  logic                          rst_n,
    // configuration write port
    input  logic                          cfg_we,
    input  logic [alp_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [alp_pkg::DELAY_W-1:0]   cfg_data,
    // request stream
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [7:0]                    s_axis_tdata,  // pin_low, pin_mid, pin_high, 0s
    input  logic                          s_axis_tuser,  // kind
    // result stream
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [7:0]                    m_axis_tdata   // drive_a, drive_b, level_low,
                                                         // level_mid, level_high, 0s
);
    import alp_pkg::*;

    logic [DELAY_W-1:0]    delay_reg [NUM_PROBES];
    logic                  in_valid_reg;
    logic                  in_kind_reg;
    logic [NUM_PROBES-1:0] in_pins_reg;
    logic                  out_valid_reg;
    logic [7:0]            out_data_reg;
    logic                  advance;
    logic                  sense_step;
    phase_t                phase;
    logic [1:0]            drive_next;
    logic [NUM_PROBES-1:0] level_next;

    // Delay registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_PROBES; i++)
            begin
                delay_reg[i] <= '0;
            end
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_DELAY_LOW:  delay_reg[0] <= cfg_data;
                REG_DELAY_MID:  delay_reg[1] <= cfg_data;
                REG_DELAY_HIGH: delay_reg[2] <= cfg_data;
                default:        ;
            endcase
        end
    end

    // Handshake: process when the result register is free or draining
    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;
    assign sense_step    = advance && (in_kind_reg == KIND_SENSE);

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            in_kind_reg <= s_axis_tuser;
            in_pins_reg <= s_axis_tdata[NUM_PROBES-1:0];
        end
    end

    // Sequencer
    alp_seq u_seq (
        .clk        (clk),
        .rst_n      (rst_n),
        .step_en    (sense_step),
        .phase      (phase),
        .drive_next (drive_next)
    );

    // Probe qualifiers
    for (genvar g = 0; g < NUM_PROBES; g++)
    begin : g_probe
        probe_ctl_t ctl;

        assign ctl.sample_en = sense_step && (phase == PH_SAMPLE);
        assign ctl.count_en  = advance && (in_kind_reg == KIND_DELAY);
        assign ctl.sample    = ~in_pins_reg[g];

        alp_probe u_probe (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctl        (ctl),
            .delay      (delay_reg[g]),
            .level_next (level_next[g])
        );
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_data_reg <= {3'b000, level_next, drive_next};
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    // Checks
    a_drive_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        drive_next != DRV_AB)
        else $error("both drive lines high");

    a_phase_moves: assert property (@(posedge clk) disable iff (!rst_n)
        sense_step |=> phase != $past(phase))
        else $error("sense tick did not advance the phase");

    a_phase_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !sense_step |=> phase == $past(phase))
        else $error("phase moved without a sense tick");

    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(advance))
        else $error("result valid without a processed request");

endmodule
